@@ rtl/connect_string_key_value_parser_defines.svh @@
// ---------------------------------------------------------------------------
// Connect string parser assertion macros
// Shared concurrent check forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef CONNECT_STRING_KEY_VALUE_PARSER_DEFINES_SVH
`define CONNECT_STRING_KEY_VALUE_PARSER_DEFINES_SVH

// Same-cycle implication
`define CSKV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CSKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cskv_pkg.sv @@
// ---------------------------------------------------------------------------
// Connect string parser package
// Shared types and constants for the front, queue and back stages.
// ---------------------------------------------------------------------------
package cskv_pkg;

    localparam int NUM_NAMES  = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // configuration register indexes
    localparam logic [2:0] REG_NAME_COUNT = 3'd0;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // queue operation: what the back stage must emit
    typedef enum logic [1:0] {
        OP_BYTE     = 2'd0,  // one value byte
        OP_DONE     = 2'd1,  // value complete
        OP_END      = 2'd2,  // end of string
        OP_DONE_END = 2'd3   // value complete, then end of string
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] field;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } fifo_stat_t;

endpackage

@@ rtl/cskv_fifo.sv @@
// ---------------------------------------------------------------------------
// Connect string parser operation queue
// Small register queue decoupling the parse front from the output back.
// ---------------------------------------------------------------------------
module cskv_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cskv_pkg::entry_t     push_entry,
    input  logic                 pop,
    output cskv_pkg::entry_t     head,
    output cskv_pkg::fifo_stat_t stat
);

    cskv_pkg::entry_t mem_reg [cskv_pkg::FIFO_DEPTH];
    logic [cskv_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cskv_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cskv_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign stat.full  = (count_reg == cskv_pkg::FIFO_CNT_W'(cskv_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;
    assign head       = mem_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (do_push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (do_pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ rtl/cskv_front.sv @@
// ---------------------------------------------------------------------------
// Connect string parser front
// Per-byte scan state, key capture, name match and value classification.
// ---------------------------------------------------------------------------
module cskv_front #(
    parameter int NAME_SLOTS = 7,
    parameter int NAME_CHARS = 8,
    parameter int VALUE_MAX  = 1023
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       in_byte,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_idx,
    input  logic [63:0]      cfg_wdata,
    output logic             push,
    output cskv_pkg::entry_t push_entry
);

    localparam int KLEN_W = $clog2(NAME_CHARS + 1);
    localparam int VLEN_W = $clog2(VALUE_MAX + 1);

    typedef enum logic [1:0] {
        M_KEY    = 2'd0,
        M_SKIP   = 2'd1,
        M_PLAIN  = 2'd2,
        M_QUOTED = 2'd3
    } mode_t;

    mode_t                              mode_reg, mode_next;
    logic                               qp_reg, qp_next;
    logic [63:0]                        key_reg, key_next;
    logic [KLEN_W-1:0]                  klen_reg, klen_next;
    logic [VLEN_W-1:0]                  vlen_reg, vlen_next;
    logic [2:0]                         cur_reg, cur_next;
    logic                               matched_reg, matched_next;
    logic [cskv_pkg::NUM_NAMES-1:0]     taken_reg, taken_next;
    logic [2:0]                         name_count_reg;
    logic [63:0]                        names_reg [cskv_pkg::NUM_NAMES];

    logic [2:0]                         lim;
    logic [cskv_pkg::NUM_NAMES-1:0]     hit;
    logic                               any_hit;
    logic [2:0]                         hit_idx;
    logic [7:0]                         low_c;
    logic                               emitting;

    // name compare against the live key, lowest index wins
    always_comb begin
        lim = (name_count_reg > 3'(NAME_SLOTS)) ? 3'(NAME_SLOTS) : name_count_reg;
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < cskv_pkg::NUM_NAMES; i++) begin
            hit[i] = (3'(i) < lim) && (names_reg[i] == key_reg);
        end
        for (int i = cskv_pkg::NUM_NAMES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                any_hit = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    assign low_c = ((in_byte >= cskv_pkg::CH_UP_A) && (in_byte <= cskv_pkg::CH_UP_Z)) ?
                   in_byte + cskv_pkg::CASE_OFS : in_byte;
    assign emitting = matched_reg && !taken_reg[cur_reg];

    always_comb begin
        logic do_vb;
        logic do_app;
        logic is_blank;
        do_vb    = 1'b0;
        do_app   = 1'b0;
        is_blank = (in_byte <= cskv_pkg::CH_SPACE);

        mode_next    = mode_reg;
        qp_next      = qp_reg;
        key_next     = key_reg;
        klen_next    = klen_reg;
        vlen_next    = vlen_reg;
        cur_next     = cur_reg;
        matched_next = matched_reg;
        taken_next   = taken_reg;
        push         = 1'b0;
        push_entry.op    = cskv_pkg::OP_BYTE;
        push_entry.field = cur_reg;
        push_entry.data  = in_byte;

        if (mode_reg == M_KEY) begin
            if (in_byte == cskv_pkg::CH_NUL) begin
                push          = 1'b1;
                push_entry.op = cskv_pkg::OP_END;
                push_entry.field = '0;
                push_entry.data  = '0;
                key_next     = '0;
                klen_next    = '0;
                vlen_next    = '0;
                cur_next     = '0;
                matched_next = 1'b0;
                taken_next   = '0;
                qp_next      = 1'b0;
            end else if (is_blank) begin
                // skipped
            end else if (in_byte == cskv_pkg::CH_SEMI) begin
                key_next  = '0;
                klen_next = '0;
            end else if (in_byte == cskv_pkg::CH_EQ) begin
                matched_next = any_hit;
                cur_next     = hit_idx;
                key_next     = '0;
                klen_next    = '0;
                mode_next    = M_SKIP;
            end else if (klen_reg < KLEN_W'(NAME_CHARS)) begin
                for (int j = 0; j < NAME_CHARS; j++) begin
                    if (klen_reg == KLEN_W'(j)) begin
                        key_next[8*j +: 8] = low_c;
                    end
                end
                klen_next = klen_reg + 1'b1;
            end
        end else begin
            if (mode_reg == M_SKIP) begin
                if (is_blank && (in_byte != cskv_pkg::CH_NUL)) begin
                    do_vb = 1'b0;
                end else begin
                    mode_next = M_PLAIN;
                    do_vb     = 1'b1;
                end
            end else if (qp_reg) begin
                qp_next = 1'b0;
                if (in_byte == cskv_pkg::CH_QUOTE) begin
                    do_app = 1'b1;   // doubled quote: literal
                end else begin
                    mode_next = (mode_reg == M_PLAIN) ? M_QUOTED : M_PLAIN;
                    do_vb     = 1'b1;
                end
            end else begin
                do_vb = 1'b1;
            end

            if (do_vb) begin
                if (in_byte == cskv_pkg::CH_NUL) begin
                    mode_next = M_PLAIN;
                end
                if ((mode_next == M_PLAIN) && (is_blank || (in_byte == cskv_pkg::CH_SEMI))) begin
                    // value ends
                    vlen_next = '0;
                    mode_next = M_KEY;
                    if (emitting) begin
                        push          = 1'b1;
                        push_entry.op = cskv_pkg::OP_DONE;
                        push_entry.data = '0;
                        taken_next[cur_reg] = 1'b1;
                    end
                    if (in_byte == cskv_pkg::CH_NUL) begin
                        push = 1'b1;
                        if (emitting) begin
                            push_entry.op = cskv_pkg::OP_DONE_END;
                        end else begin
                            push_entry.op    = cskv_pkg::OP_END;
                            push_entry.field = '0;
                            push_entry.data  = '0;
                        end
                        qp_next      = 1'b0;
                        key_next     = '0;
                        klen_next    = '0;
                        cur_next     = '0;
                        matched_next = 1'b0;
                        taken_next   = '0;
                    end
                end else if (in_byte == cskv_pkg::CH_QUOTE) begin
                    qp_next = 1'b1;
                end else begin
                    do_app = 1'b1;
                end
            end

            if (do_app && (vlen_reg < VLEN_W'(VALUE_MAX))) begin
                vlen_next = vlen_reg + 1'b1;
                if (emitting) begin
                    push          = 1'b1;
                    push_entry.op = cskv_pkg::OP_BYTE;
                end
            end
        end

        if (!step) begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            mode_reg       <= M_KEY;
            qp_reg         <= 1'b0;
            key_reg        <= '0;
            klen_reg       <= '0;
            vlen_reg       <= '0;
            cur_reg        <= '0;
            matched_reg    <= 1'b0;
            taken_reg      <= '0;
            name_count_reg <= '0;
            for (int i = 0; i < cskv_pkg::NUM_NAMES; i++) begin
                names_reg[i] <= '0;
            end
        end else begin
            if (step) begin
                mode_reg    <= mode_next;
                qp_reg      <= qp_next;
                key_reg     <= key_next;
                klen_reg    <= klen_next;
                vlen_reg    <= vlen_next;
                cur_reg     <= cur_next;
                matched_reg <= matched_next;
                taken_reg   <= taken_next;
            end
            if (cfg_we) begin
                if (cfg_idx == cskv_pkg::REG_NAME_COUNT) begin
                    name_count_reg <= cfg_wdata[2:0];
                end else begin
                    names_reg[cfg_idx - 3'd1] <= cfg_wdata;
                end
            end
        end
    end

endmodule

@@ rtl/cskv_back.sv @@
// ---------------------------------------------------------------------------
// Connect string parser back
// Expands queued operations into result words behind an output register.
// ---------------------------------------------------------------------------
module cskv_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cskv_pkg::entry_t     head,
    input  cskv_pkg::fifo_stat_t stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    logic       valid_reg, valid_next;
    logic [1:0] kind_reg, kind_next;
    logic [2:0] field_reg, field_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       pend_end_reg, pend_end_next;
    logic       load;

    assign load = !valid_reg || m_tready;

    always_comb begin
        valid_next    = valid_reg;
        kind_next     = kind_reg;
        field_next    = field_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        pend_end_next = pend_end_reg;
        pop           = 1'b0;
        if (load) begin
            if (pend_end_reg) begin
                // second word of a done+end pair
                valid_next    = 1'b1;
                kind_next     = cskv_pkg::KIND_END;
                field_next    = '0;
                byte_next     = '0;
                last_next     = 1'b1;
                pend_end_next = 1'b0;
            end else if (!stat.empty) begin
                pop        = 1'b1;
                valid_next = 1'b1;
                field_next = head.field;
                byte_next  = '0;
                last_next  = 1'b0;
                case (head.op)
                    cskv_pkg::OP_BYTE: begin
                        kind_next = cskv_pkg::KIND_BYTE;
                        byte_next = head.data;
                    end
                    cskv_pkg::OP_DONE: begin
                        kind_next = cskv_pkg::KIND_DONE;
                    end
                    cskv_pkg::OP_END: begin
                        kind_next  = cskv_pkg::KIND_END;
                        field_next = '0;
                        last_next  = 1'b1;
                    end
                    cskv_pkg::OP_DONE_END: begin
                        kind_next     = cskv_pkg::KIND_DONE;
                        pend_end_next = 1'b1;
                    end
                    default: begin
                        kind_next = cskv_pkg::KIND_BYTE;
                    end
                endcase
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg    <= 1'b0;
            pend_end_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            pend_end_reg <= pend_end_next;
        end
    end

    always_ff @(posedge clk) begin
        kind_reg  <= kind_next;
        field_reg <= field_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'b0, byte_reg, field_reg};

endmodule

@@ rtl/connect_string_key_value_parser.sv @@
// Path: a byte's queue word is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue has room; a string terminator
//   that also closes a matched value yields two words, which the single output
//   port takes singly, so the four-entry queue fills only under that or back-pressure.
// Reset: aresetn synchronous, active low; clears scan state, name registers
//   and the queue. No clearing pass.
// ---------------------------------------------------------------------------
// Connect string key/value parser
// Streams connect string bytes, matches keys against configured names and
// emits the bytes of matching values plus completion and end markers.
// ---------------------------------------------------------------------------
`include "connect_string_key_value_parser_defines.svh"

module connect_string_key_value_parser #(
    parameter int NAME_SLOTS = 7,     // names compared, 1..7
    parameter int NAME_CHARS = 8,     // key characters kept, 1..8
    parameter int VALUE_MAX  = 1023   // value bytes kept, 1..1023
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] in_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [2:0] field_index, [10:3] value_byte, rest zero
    output logic [1:0]  m_tuser,     // [1:0] kind
    output logic        m_tlast,     // last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,   // 0 name_count, 1..7 name_0..name_6
    input  logic [63:0] cfg_data
);

    logic                 step;
    logic                 front_push;
    cskv_pkg::entry_t     front_entry;
    cskv_pkg::entry_t     q_head;
    cskv_pkg::fifo_stat_t q_stat;
    logic                 q_pop;

    // The front produces at most one queue word per byte, so room in the
    // queue is all it needs to take a byte.
    assign s_tready  = !q_stat.full;
    assign step      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Front: scan state machine, key capture and the parallel name compare.
    cskv_front #(
        .NAME_SLOTS (NAME_SLOTS),
        .NAME_CHARS (NAME_CHARS),
        .VALUE_MAX  (VALUE_MAX)
    ) u_front (
        .clk        (aclk),
        .rst_n      (aresetn),
        .step       (step),
        .in_byte    (s_tdata),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .push       (front_push),
        .push_entry (front_entry)
    );

    // Queue between front and back.
    cskv_fifo u_fifo (
        .clk        (aclk),
        .rst_n      (aresetn),
        .push       (front_push),
        .push_entry (front_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    // Back: turns queue words into result words on the output register.
    cskv_back u_back (
        .clk      (aclk),
        .rst_n    (aresetn),
        .head     (q_head),
        .stat     (q_stat),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Checks
    `CSKV_ASSERT_NOW(a_q_bound, aclk, aresetn, 1'b1, q_stat.count <= 3'(cskv_pkg::FIFO_DEPTH), "queue count beyond depth")
    `CSKV_ASSERT_NOW(a_last_end, aclk, aresetn, m_tvalid && m_tlast, (m_tuser == cskv_pkg::KIND_END) && (m_tdata == 16'd0), "tlast on a word that is not end of string")
    `CSKV_ASSERT_NEXT(a_push_room, aclk, aresetn, q_stat.full && !q_pop, !s_tready, "byte taken while queue full")

endmodule

@@ test/tb_connect_string_key_value_parser.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Connect string key/value parser testbench
// Sends connect strings one byte per word and predicts every result word
// (value bytes, value complete, end of string) with its own model of the
// parser. The block is reconfigured between sections only when it is idle.
// Sender and receiver idle at random.
// ---------------------------------------------------------------------------
module tb_connect_string_key_value_parser;

    localparam int NAME_SLOTS = 7;
    localparam int NAME_CHARS = 8;
    localparam int VALUE_MAX  = 1023;

    localparam logic [2:0] REG_NAME_0 = 3'd1;  // name_k sits at REG_NAME_0 + k

    localparam int SECTIONS        = 6;
    localparam int SECTION_BYTES   = 40;    // per section; one long value adds ~1000 more
    localparam int SETTLE_CYCLES   = 16;    // covers the queue and output register path with margin
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any handshake

    // parser scan modes
    typedef enum logic [1:0] {
        SCAN_KEY    = 2'd0,
        SCAN_SKIP   = 2'd1,  // blanks between '=' and the value
        SCAN_PLAIN  = 2'd2,
        SCAN_QUOTED = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] field;
        logic [7:0] value;
        logic       last;
    } parse_word_t;

    // -----------------------------------------------------------------------
    // Scoreboard: tracks parser state and holds the result words still owed
    // -----------------------------------------------------------------------
    class parse_scoreboard;
        logic [2:0]  name_count;
        logic [63:0] names [NAME_SLOTS];
        scan_mode_t  mode;
        bit          quote_held;
        logic [63:0] key_buf;
        int          key_len;
        int          value_len;
        logic [2:0]  field;
        bit          matched;
        logic [6:0]  taken;
        parse_word_t expected_q [$];
        int          errors;

        function new();
            name_count = '0;
            foreach (names[i]) names[i] = '0;
            errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode       = SCAN_KEY;
            quote_held = 0;
            key_buf    = '0;
            key_len    = 0;
            value_len  = 0;
            field      = '0;
            matched    = 0;
            taken      = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            if (idx == cskv_pkg::REG_NAME_COUNT)
                name_count = val[2:0];
            else
                names[idx - REG_NAME_0] = val;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void owe(logic [1:0] kind, logic [2:0] fld, logic [7:0] val, logic last);
            parse_word_t w;
            w.kind  = kind;
            w.field = fld;
            w.value = val;
            w.last  = last;
            expected_q.push_back(w);
        endfunction

        // a value is passed on only for a matched name not yet completed
        function bit emitting();
            return matched && !taken[field];
        endfunction

        function void add_value_byte(logic [7:0] b);
            if (value_len >= VALUE_MAX)
                return;
            value_len++;
            if (emitting())
                owe(cskv_pkg::KIND_BYTE, field, b, 1'b0);
        endfunction

        function void end_of_string();
            owe(cskv_pkg::KIND_END, 3'd0, 8'd0, 1'b1);
            clear_scan();
        endfunction

        function void value_char(logic [7:0] b);
            if (b == cskv_pkg::CH_NUL)
                mode = SCAN_PLAIN;  // terminator closes even a quoted value
            if (mode == SCAN_PLAIN && (b <= cskv_pkg::CH_SPACE || b == cskv_pkg::CH_SEMI)) begin
                if (emitting()) begin
                    owe(cskv_pkg::KIND_DONE, field, 8'd0, 1'b0);
                    taken[field] = 1'b1;
                end
                value_len = 0;
                mode = SCAN_KEY;
                if (b == cskv_pkg::CH_NUL)
                    end_of_string();
                return;
            end
            if (b == cskv_pkg::CH_QUOTE) begin
                quote_held = 1;
                return;
            end
            add_value_byte(b);
        endfunction

        function void match_key();
            int lim;
            lim = (int'(name_count) > NAME_SLOTS) ? NAME_SLOTS : int'(name_count);
            matched = 0;
            field = '0;
            for (int i = 0; i < lim; i++) begin
                if (names[i] == key_buf) begin
                    matched = 1;
                    field = i[2:0];
                    break;
                end
            end
            key_buf = '0;
            key_len = 0;
            mode = SCAN_SKIP;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [7:0] c;
            case (mode)
                SCAN_KEY: begin
                    if (b == cskv_pkg::CH_NUL) begin
                        end_of_string();
                    end else if (b <= cskv_pkg::CH_SPACE) begin
                        // blank inside a key: skipped
                    end else if (b == cskv_pkg::CH_SEMI) begin
                        key_buf = '0;
                        key_len = 0;
                    end else if (b == cskv_pkg::CH_EQ) begin
                        match_key();
                    end else if (key_len < NAME_CHARS) begin
                        c = (b >= cskv_pkg::CH_UP_A && b <= cskv_pkg::CH_UP_Z) ?
                            b + cskv_pkg::CASE_OFS : b;
                        key_buf[8*key_len +: 8] = c;
                        key_len++;
                    end
                end
                SCAN_SKIP: begin
                    if (b == cskv_pkg::CH_NUL || b > cskv_pkg::CH_SPACE) begin
                        mode = SCAN_PLAIN;
                        value_char(b);
                    end
                end
                default: begin
                    if (quote_held) begin
                        quote_held = 0;
                        if (b == cskv_pkg::CH_QUOTE) begin
                            add_value_byte(b);  // doubled quote: literal
                            return;
                        end
                        mode = (mode == SCAN_PLAIN) ? SCAN_QUOTED : SCAN_PLAIN;
                    end
                    value_char(b);
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(logic [1:0] kind, logic [15:0] tdata, logic last);
            parse_word_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word kind %0d field %0d byte %h last %b",
                                 kind, tdata[2:0], tdata[10:3], last));
                return;
            end
            want = expected_q.pop_front();
            if (kind != want.kind || tdata[2:0] != want.field || tdata[10:3] != want.value
                    || last != want.last || tdata[15:11] != '0)
                report($sformatf("got kind %0d field %0d byte %h last %b pad %h, want %0d %0d %h %b",
                                 kind, tdata[2:0], tdata[10:3], last, tdata[15:11],
                                 want.kind, want.field, want.value, want.last));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // DUT signals; the inputs are known from time zero
    // -----------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // [2:0] field_index, [10:3] value_byte, rest zero
    logic [1:0]  m_tuser;            // [1:0] kind
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;     // 0 name_count, 1..7 name_0..name_6
    logic [63:0] cfg_data  = '0;

    connect_string_key_value_parser uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    parse_scoreboard sb = new();

    int          send_idle   = 0;    // percent of cycles the sender holds off
    int          recv_idle   = 0;    // percent of cycles the receiver stalls
    int          items_sent  = 0;
    int          quiet_cycles = 0;
    bit          long_pending = 0;   // next random value is built near VALUE_MAX, possibly past it
    logic [63:0] name_cfg [NAME_SLOTS];
    logic [7:0]  text_q [$];

    // -----------------------------------------------------------------------
    // Monitor: receiver back-pressure, result checks, input and config
    // tracking, and the no-progress counter. Values are sampled pre-edge.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (aresetn) begin
            // results first: a word can never stem from a byte of this edge
            if (m_tvalid && m_tready)
                sb.check_word(m_tuser, m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: stuck handshake or results that never come
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[connect_string_key_value_parser] ERROR");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));  // garbage while idle
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i]);
        text_q.delete();
    endtask

    // cfg_valid stays up across back-to-back writes; the caller lowers it
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [2:0] count);
        write_reg(cskv_pkg::REG_NAME_COUNT, {61'd0, count});
        for (int k = 0; k < NAME_SLOTS; k++)
            write_reg(REG_NAME_0 + 3'(k), name_cfg[k]);
        cfg_valid <= 1'b0;
    endtask

    // let every owed word arrive, then give in-flight bytes time to settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic logic [63:0] pack_name(input string s);
        logic [63:0] nm;
        nm = '0;
        for (int k = 0; k < s.len() && k < 8; k++) nm[8*k +: 8] = s[k];
        return nm;
    endfunction

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endfunction

    // short names over a tiny alphabet so keys collide and match often
    function automatic logic [63:0] rand_name();
        logic [63:0] nm;
        int          len;
        int          r;
        nm = '0;
        r = int'($urandom_range(15));
        if (r == 0) return '0;   // matches the empty key
        if (r == 1) return '1;   // eight 0xFF characters
        len = (r == 2) ? NAME_CHARS : int'($urandom_range(1, NAME_CHARS));
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(7) == 0)
                nm[8*k +: 8] = 8'($urandom_range(128, 255));
            else
                nm[8*k +: 8] = 8'($urandom_range(8'h61, 8'h64));
        end
        return nm;
    endfunction

    // any byte a key may carry
    function automatic logic [7:0] key_char();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255));
        while (c == cskv_pkg::CH_SEMI || c == cskv_pkg::CH_EQ);
        return c;
    endfunction

    // ordinary unquoted value byte
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255));
        while (c == cskv_pkg::CH_SEMI || c == cskv_pkg::CH_QUOTE);
        return c;
    endfunction

    // One random connect string: mostly well-formed key=value pairs with
    // random content, some noise and broken pairs, always terminated.
    function automatic void build_string();
        int          pairs;
        int          n;
        int          j;
        int          vlen;
        int          r;
        bit          quoted;
        logic [63:0] nm;
        logic [7:0]  c;
        pairs = int'($urandom_range(0, 4));
        for (int i = 0; i < pairs; i++) begin
            if ($urandom_range(99) < 12) begin
                n = int'($urandom_range(1, 8));
                repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
                continue;
            end
            if ($urandom_range(3) == 0)
                text_q.push_back(8'($urandom_range(1, 32)));
            // key: a configured name with random case, or random junk
            if ($urandom_range(4) == 0) begin
                n = int'($urandom_range(0, 10));
                repeat (n) text_q.push_back(key_char());
            end else begin
                nm = name_cfg[$urandom_range(0, NAME_SLOTS - 1)];
                for (j = 0; j < 8; j++) begin
                    c = nm[8*j +: 8];
                    if (c == cskv_pkg::CH_NUL) break;
                    if (c >= 8'h61 && c <= 8'h7A && $urandom_range(2) == 0)
                        c = c - cskv_pkg::CASE_OFS;
                    if ($urandom_range(11) == 0)
                        text_q.push_back(8'($urandom_range(1, 32)));
                    text_q.push_back(c);
                end
                if (j == 8 && $urandom_range(1) == 0) begin
                    n = int'($urandom_range(1, 3));  // overlong key, tail dropped
                    repeat (n) text_q.push_back(key_char());
                end
            end
            if ($urandom_range(9) == 0) begin
                text_q.push_back(cskv_pkg::CH_SEMI);     // key abandoned
                continue;
            end
            text_q.push_back(cskv_pkg::CH_EQ);
            n = int'($urandom_range(0, 2));
            repeat (n) text_q.push_back(8'($urandom_range(1, 32)));
            // value
            vlen = long_pending ? int'($urandom_range(VALUE_MAX - 3, VALUE_MAX + 7))
                                : int'($urandom_range(0, 6));
            long_pending = 0;
            quoted = ($urandom_range(2) == 0);
            if (quoted) text_q.push_back(cskv_pkg::CH_QUOTE);
            for (j = 0; j < vlen; j++) begin
                r = int'($urandom_range(9));
                if (r == 0) begin
                    text_q.push_back(cskv_pkg::CH_QUOTE);
                    text_q.push_back(cskv_pkg::CH_QUOTE);
                end else if (r == 1 && quoted) begin
                    text_q.push_back(8'($urandom_range(1, 32)));
                end else if (r == 2 && !quoted && $urandom_range(3) == 0) begin
                    text_q.push_back(cskv_pkg::CH_QUOTE);  // lone quote flips quoting
                end else begin
                    text_q.push_back(plain_char());
                end
            end
            if (quoted && $urandom_range(7) != 0)
                text_q.push_back(cskv_pkg::CH_QUOTE);
            if (i < pairs - 1 || $urandom_range(1) == 0)
                text_q.push_back(($urandom_range(1) == 0) ? cskv_pkg::CH_SEMI
                                                           : 8'($urandom_range(1, 32)));
        end
        text_q.push_back(cskv_pkg::CH_NUL);
    endfunction

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        logic [2:0] count;
        int         target;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: case folding, blanks, quoting, doubled quote,
        // duplicate key, high bytes, terminator inside a pending quote
        name_cfg[0] = pack_name("host");
        name_cfg[1] = pack_name("p");
        name_cfg[2] = '1;
        name_cfg[3] = pack_name("abcdefgh");
        name_cfg[4] = pack_name("user");
        name_cfg[5] = pack_name("x");
        name_cfg[6] = '0;
        configure(3'd7);
        push_text("HOST= 'a''b' ;host=z");
        text_q.push_back(cskv_pkg::CH_NUL);
        push_text("p=");
        text_q.push_back(8'h80);
        text_q.push_back(cskv_pkg::CH_QUOTE);
        text_q.push_back(cskv_pkg::CH_NUL);
        send_text();
        drain();

        // random sections: three idle patterns, each under two settings
        for (int sect = 0; sect < SECTIONS; sect++) begin
            case (sect / 2)
                0: begin send_idle = 10; recv_idle = 65; end
                1: begin send_idle = 65; recv_idle = 10; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            case (sect)
                0, 2, 4: count = 3'd7;
                3:       count = 3'd0;
                default: count = 3'($urandom_range(0, 7));
            endcase
            foreach (name_cfg[k]) name_cfg[k] = rand_name();
            configure(count);
            long_pending = (sect == 4);
            target = items_sent + SECTION_BYTES;
            while (items_sent < target) begin
                build_string();
                send_text();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("[connect_string_key_value_parser] OK");
        else
            $display("[connect_string_key_value_parser] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cskv_pkg.sv
rtl/cskv_fifo.sv
rtl/cskv_front.sv
rtl/cskv_back.sv
rtl/connect_string_key_value_parser.sv
test/tb_connect_string_key_value_parser.sv
